// File: rtl/art_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// art_pkg
// Shared types, codes and saturating helpers for the allocation tracker.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int CNT_W  = 32;
    localparam int LIVE_W = 7;
    localparam int SLOT_W = 6;

    localparam logic [LIVE_W-1:0] LIVE_MAX = 7'd127;

    // register index of tracking_enable
    localparam logic REG_TRACK_EN = 1'b0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } art_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_RESP
    } art_state_t;

    typedef struct packed {
        logic             alloc;
        logic             rel;
        logic [CNT_W-1:0] size;
    } art_upd_t;

    typedef struct packed {
        logic [LIVE_W-1:0] live;
        logic [CNT_W-1:0]  alloc_cnt;
        logic [CNT_W-1:0]  rel_cnt;
        logic [CNT_W-1:0]  usage;
        logic [CNT_W-1:0]  peak;
        logic [CNT_W-1:0]  alloc_sum;
        logic [CNT_W-1:0]  rel_sum;
    } art_stats_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (b > a) ? '0 : (a - b);
    endfunction

endpackage
`default_nettype wire

// File: rtl/allocation_record_tracker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// allocation_record_tracker_core
// Leak-tracking table of live address/size records with running statistics.
// ----------------------------------------------------------------------------
// A disabled or invalid event returns its word in the cycle after start;
//   a tracked event is paced by the one-slot-a-cycle walk over the address
//   RAM read port.
// One event at a time: busy stays high through the result strobe, so the
//   next start is taken the cycle after it.
// Reset: after rst_n rises, a clearing pass writes every address slot to
//   zero with busy high; APB writes are taken.
// The receiver cannot stall: done marks a result for exactly one cycle.
// ----------------------------------------------------------------------------
module allocation_record_tracker_core
    import art_pkg::*;
#(
    parameter int RECORD_SLOTS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // event command
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [31:0] block_addr,
    input  wire logic [31:0] alloc_size,
    // result word
    output logic             done,
    output logic [1:0]       status,
    output logic [5:0]       slot_used,
    output logic [6:0]       live_records,
    output logic [31:0]      alloc_total_count,
    output logic [31:0]      release_total_count,
    output logic [31:0]      bytes_in_use,
    output logic [31:0]      bytes_in_use_peak,
    output logic [31:0]      bytes_allocated_total,
    output logic [31:0]      bytes_released_total
);

    localparam int IDX_W = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_SLOTS - 1);

    // ------------------------------------------------------------------
    // APB: single register, index taken from paddr[2]
    // ------------------------------------------------------------------
    logic cfg_wr;
    logic enable_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TRACK_EN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_TRACK_EN) ? {31'b0, enable_reg} : '0;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    art_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;          // clear / issue pointer
    logic              issue_done_reg, issue_done_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;  // slot whose data is back
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [31:0]       hit_size_reg, hit_size_next;
    art_status_t       status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // latched event (payload, no reset)
    logic              mode_reg;
    logic [31:0]       addr_reg;
    logic [31:0]       size_reg;

    // memory ports
    logic              ram_re;
    logic              addr_we;
    logic [IDX_W-1:0]  addr_waddr;
    logic [31:0]       addr_wdata;
    logic              size_we;
    logic [31:0]       addr_rdata;
    logic [31:0]       size_rdata;

    art_upd_t          upd;
    art_stats_t        stats;
    logic              slot_match;

    // alloc looks for an empty slot, release for the address itself
    assign slot_match = mode_reg ? (addr_rdata == addr_reg) : (addr_rdata == '0);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_size_next   = hit_size_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        ram_re          = 1'b0;
        addr_we         = 1'b0;
        addr_waddr      = hit_idx_reg;
        addr_wdata      = mode_reg ? 32'd0 : addr_reg;
        size_we         = 1'b0;
        upd             = '0;
        upd.size        = mode_reg ? hit_size_reg : size_reg;

        case (state_reg)
            S_CLEAR:
            begin
                addr_we    = 1'b1;
                addr_waddr = idx_reg;
                addr_wdata = '0;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    slot_next = '0;
                    if (!enable_reg)
                    begin
                        status_next = ST_OK;
                        state_next  = S_RESP;
                    end
                    else if (block_addr == '0 || (!mode && alloc_size == '0))
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        idx_next        = '0;
                        issue_done_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read a cycle, compare the word that came back
                ram_re = !issue_done_reg;
                if (!issue_done_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (chk_valid_reg && slot_match)
                begin
                    hit_idx_next   = chk_idx_reg;
                    hit_size_next  = size_rdata;
                    chk_valid_next = 1'b0;
                    state_next     = S_UPDATE;
                end
                else if (chk_valid_reg && chk_idx_reg == LAST_IDX)
                begin
                    status_next    = mode_reg ? ST_NOT_FOUND : ST_FULL;
                    chk_valid_next = 1'b0;
                    state_next     = S_RESP;
                end
            end

            S_UPDATE:
            begin
                // write back the slot and fold the event into the stats
                addr_we     = 1'b1;
                size_we     = !mode_reg;
                upd.alloc   = !mode_reg;
                upd.rel     = mode_reg;
                status_next = ST_OK;
                slot_next   = SLOT_W'(hit_idx_reg);
                state_next  = S_RESP;
            end

            S_RESP:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            chk_idx_reg    <= '0;
            status_reg     <= ST_OK;
            slot_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            chk_valid_reg  <= chk_valid_next;
            chk_idx_reg    <= chk_idx_next;
            status_reg     <= status_next;
            slot_reg       <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        hit_size_reg <= hit_size_next;
        if (state_reg == S_IDLE && start)
        begin
            mode_reg <= mode;
            addr_reg <= block_addr;
            size_reg <= alloc_size;
        end
    end

    // ------------------------------------------------------------------
    // Table memories: both read at the scan pointer
    // ------------------------------------------------------------------
    art_ram #(
        .WIDTH (32),
        .DEPTH (RECORD_SLOTS)
    ) u_addr_ram (
        .clk   (clk),
        .we    (addr_we),
        .waddr (addr_waddr),
        .wdata (addr_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (addr_rdata)
    );

    art_ram #(
        .WIDTH (32),
        .DEPTH (RECORD_SLOTS)
    ) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .waddr (hit_idx_reg),
        .wdata (size_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (size_rdata)
    );

    // ------------------------------------------------------------------
    // Statistics
    // ------------------------------------------------------------------
    art_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cfg_wr && pwdata[0]),
        .upd   (upd),
        .stats (stats)
    );

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy                  = (state_reg != S_IDLE);
    assign done                  = (state_reg == S_RESP);
    assign status                = status_reg;
    assign slot_used             = slot_reg;
    assign live_records          = stats.live;
    assign alloc_total_count     = stats.alloc_cnt;
    assign release_total_count   = stats.rel_cnt;
    assign bytes_in_use          = stats.usage;
    assign bytes_in_use_peak     = stats.peak;
    assign bytes_allocated_total = stats.alloc_sum;
    assign bytes_released_total  = stats.rel_sum;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_write_only_owned: assert property (@(posedge clk) disable iff (!rst_n)
        addr_we |-> (state_reg == S_UPDATE || state_reg == S_CLEAR))
        else $error("table write outside update or clear");

    a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done && status_reg != ST_OK |-> slot_reg == '0)
        else $error("failed event reports a slot");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_update_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPDATE |=> done && status_reg == ST_OK)
        else $error("update not followed by ok result");

endmodule
`default_nettype wire

// File: rtl/art_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// art_ram
// Generic single-write, single-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module art_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/art_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// art_stats
// Running statistics: live count, counters, usage, peak and byte totals.
// ----------------------------------------------------------------------------
module art_stats
    import art_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       clear,   // enable written with 1
    input  wire art_upd_t   upd,
    output art_stats_t      stats
);

    art_stats_t       stats_reg, stats_next;
    logic [CNT_W-1:0] usage_new;

    always_comb
    begin
        stats_next = stats_reg;
        usage_new  = upd.alloc ? sat_add(stats_reg.usage, upd.size)
                               : sat_sub(stats_reg.usage, upd.size);
        if (clear)
        begin
            stats_next.alloc_cnt = '0;
            stats_next.rel_cnt   = '0;
            stats_next.usage     = '0;
            stats_next.peak      = '0;
            stats_next.alloc_sum = '0;
            stats_next.rel_sum   = '0;
        end
        else if (upd.alloc)
        begin
            if (stats_reg.live != LIVE_MAX)
            begin
                stats_next.live = stats_reg.live + 1'b1;
            end
            stats_next.alloc_cnt = sat_add(stats_reg.alloc_cnt, CNT_W'(1));
            stats_next.usage     = usage_new;
            stats_next.alloc_sum = sat_add(stats_reg.alloc_sum, upd.size);
            if (usage_new > stats_reg.peak)
            begin
                stats_next.peak = usage_new;
            end
        end
        else if (upd.rel)
        begin
            if (stats_reg.live != '0)
            begin
                stats_next.live = stats_reg.live - 1'b1;
            end
            stats_next.rel_cnt = sat_add(stats_reg.rel_cnt, CNT_W'(1));
            stats_next.usage   = usage_new;
            stats_next.rel_sum = sat_add(stats_reg.rel_sum, upd.size);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg <= '0;
        end
        else
        begin
            stats_reg <= stats_next;
        end
    end

    assign stats = stats_reg;

    // peak tracks usage from every clear onward
    a_peak_covers_usage: assert property (@(posedge clk) disable iff (!rst_n)
        stats_reg.usage <= stats_reg.peak)
        else $error("usage above peak");

    a_alloc_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !upd.alloc && !clear |=> $stable(stats_reg.alloc_cnt))
        else $error("alloc count moved without an update");

    a_rel_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !upd.rel && !clear |=> $stable(stats_reg.rel_cnt))
        else $error("release count moved without an update");

endmodule
`default_nettype wire
